@@ hdl/edacc_pkg.sv @@
// Package for the Euclidean distance accumulator: defaults, widths and link types.
`timescale 1ns / 1ps
`default_nettype none
package edacc_pkg;

    // Default coordinate and sum widths.
    localparam int COORD_BITS_DEF = 16;
    localparam int SUM_BITS_DEF   = 40;

    // Width of the distance field on the output port.
    localparam int DIST_BITS = 20;

    // Control that travels with a squared difference.
    typedef struct packed {
        logic valid;
        logic last;
    } t_item_ctl;

    // Control that travels with a sum through the root cells.
    typedef struct packed {
        logic valid;
        logic sat;
    } t_cell_ctl;

endpackage
`default_nettype wire

@@ hdl/edacc_square.sv @@
// Front stage: coordinate difference, magnitude and square, registered.
`timescale 1ns / 1ps
`default_nettype none
module edacc_square
    import edacc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire logic signed [COORD_BITS-1:0] i_p_coord,
    input  wire logic signed [COORD_BITS-1:0] i_q_coord,
    input  wire logic                         i_last_element,
    output t_item_ctl                         o_ctl,
    output logic [2*COORD_BITS+1:0]           o_sq
);

    localparam int DW = COORD_BITS + 1;

    logic [DW-1:0]           w_diff;
    logic [DW-1:0]           w_mag;
    logic [2*COORD_BITS+1:0] n_sq;
    t_item_ctl               r_ctl;
    logic [2*COORD_BITS+1:0] r_sq;

    // Sign-extended difference q - p and its magnitude, which fits unsigned in DW bits.
    always_comb begin
        w_diff = {i_q_coord[COORD_BITS-1], i_q_coord} - {i_p_coord[COORD_BITS-1], i_p_coord};
        w_mag  = w_diff[DW-1] ? (~w_diff + DW'(1)) : w_diff;
        n_sq   = (2*DW)'(w_mag) * (2*DW)'(w_mag);
    end

    // Control register: cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl.valid <= i_valid;
            r_ctl.last  <= i_last_element;
        end
    end

    // Product register.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= n_sq;
        end
    end

    assign o_ctl = r_ctl;
    assign o_sq  = r_sq;

endmodule
`default_nettype wire

@@ hdl/edacc_accum.sv @@
// Saturating sum of squares, with a flush register that hands a finished sum on.
`timescale 1ns / 1ps
`default_nettype none
module edacc_accum
    import edacc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int SUM_BITS   = SUM_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire t_item_ctl                 i_ctl,
    input  wire logic [2*COORD_BITS+1:0]   i_sq,
    output t_cell_ctl                      o_ctl,
    output logic [SUM_BITS-1:0]            o_sum
);

    localparam int SQ_W = 2 * COORD_BITS + 2;
    localparam int W    = ((SUM_BITS > SQ_W) ? SUM_BITS : SQ_W) + 1;
    localparam logic [W-1:0] SUM_MAX = {{(W-SUM_BITS){1'b0}}, {SUM_BITS{1'b1}}};

    logic [SUM_BITS-1:0] r_sum;
    logic                r_ovf;
    logic [W-1:0]        w_wide;
    logic                w_over;
    logic [SUM_BITS-1:0] n_sum;
    logic                n_ovf;
    t_cell_ctl           r_fl_ctl;
    logic [SUM_BITS-1:0] r_fl_sum;

    // Wide add, then clamp at the all-ones value of the sum.
    always_comb begin
        w_wide = W'(r_sum) + W'(i_sq);
        w_over = w_wide > SUM_MAX;
        n_sum  = w_over ? '1 : w_wide[SUM_BITS-1:0];
        n_ovf  = r_ovf | w_over;
    end

    // Running state: the last item of a vector clears it for the next vector.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_ovf <= 1'b0;
        end else if (i_en && i_ctl.valid) begin
            if (i_ctl.last) begin
                r_sum <= '0;
                r_ovf <= 1'b0;
            end else begin
                r_sum <= n_sum;
                r_ovf <= n_ovf;
            end
        end
    end

    // Flush control: valid for one step when a vector ends.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fl_ctl <= '0;
        end else if (i_en) begin
            r_fl_ctl.valid <= i_ctl.valid & i_ctl.last;
            r_fl_ctl.sat   <= n_ovf;
        end
    end

    // Flush payload.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fl_sum <= n_sum;
        end
    end

    assign o_ctl = r_fl_ctl;
    assign o_sum = r_fl_sum;

endmodule
`default_nettype wire

@@ hdl/edacc_cell.sv @@
// One digit step of the integer square root: takes two radicand bits, yields one root bit.
`timescale 1ns / 1ps
`default_nettype none
module edacc_cell
    import edacc_pkg::*;
#(
    parameter int SUM_BITS = SUM_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire t_cell_ctl                    i_ctl,
    input  wire logic [2*((SUM_BITS+1)/2)-1:0] i_rad,
    input  wire logic [(SUM_BITS+1)/2+1:0]    i_rem,
    input  wire logic [(SUM_BITS+1)/2-1:0]    i_root,
    output t_cell_ctl                         o_ctl,
    output logic [2*((SUM_BITS+1)/2)-1:0]     o_rad,
    output logic [(SUM_BITS+1)/2+1:0]         o_rem,
    output logic [(SUM_BITS+1)/2-1:0]         o_root
);

    localparam int R  = (SUM_BITS + 1) / 2;
    localparam int NW = 2 * R;
    localparam int RW = R + 2;

    logic [RW-1:0] w_rem_sh;
    logic [RW-1:0] w_trial;
    logic          w_ge;
    logic [RW-1:0] n_rem;
    logic [R-1:0]  n_root;
    logic [NW-1:0] n_rad;
    t_cell_ctl     r_ctl;
    logic [NW-1:0] r_rad;
    logic [RW-1:0] r_rem;
    logic [R-1:0]  r_root;

    // Bring down the next bit pair and try the digit one against 4*root + 1.
    always_comb begin
        w_rem_sh = {i_rem[RW-3:0], i_rad[NW-1:NW-2]};
        w_trial  = {i_root, 2'b01};
        w_ge     = w_rem_sh >= w_trial;
        n_rem    = w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
        n_root   = {i_root[R-2:0], w_ge};
        n_rad    = {i_rad[NW-3:0], 2'b00};
    end

    // Control register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    // Payload registers handed to the next cell.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule
`default_nettype wire

@@ hdl/euclidean_distance_accumulator.sv @@
// Top level of the Euclidean distance accumulator.
// Usage:
// The input channel takes one coordinate pair (p, q) per item, with a mark on
// the final element of each vector. The output channel gives one item per
// vector: the floor square root of the sum of squared differences, and a flag
// that is set when the sum saturated at all ones during that vector.
// One input item per cycle is taken while o_stall is low, at any vector length.
// After the edge that accepts the last item of its vector, a result passes
// the square register, the flush register of the sum, the row of root cells
// (one cell per root bit) and the output register.
// The whole row moves on one common enable. A result held in the output
// register by a stalled receiver does not hold the row; only when a second
// result reaches the end of the row does the row stop and o_stall rise, so
// no item is lost.
// Synchronous reset clears the sum, the saturation flag and all valid bits.
`timescale 1ns / 1ps
`default_nettype none
module euclidean_distance_accumulator
    import edacc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int SUM_BITS   = SUM_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic signed [COORD_BITS-1:0] i_p_coord,
    input  wire logic signed [COORD_BITS-1:0] i_q_coord,
    input  wire logic                         i_last_element,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [DIST_BITS-1:0]              o_distance,
    output logic                              o_saturated
);

    localparam int R  = (SUM_BITS + 1) / 2;
    localparam int NW = 2 * R;
    localparam int RW = R + 2;

    logic                    w_adv;
    t_item_ctl               w_sq_ctl;
    logic [2*COORD_BITS+1:0] w_sq;
    t_cell_ctl               w_fl_ctl;
    logic [SUM_BITS-1:0]     w_fl_sum;
    t_cell_ctl               w_ctl  [0:R];
    logic [NW-1:0]           w_rad  [0:R];
    logic [RW-1:0]           w_rem  [0:R];
    logic [R-1:0]            w_root [0:R];
    logic                    r_out_valid;
    logic [DIST_BITS-1:0]    r_out_distance;
    logic                    r_out_sat;

    // Whole pipeline advances unless a finished result at the end of the row
    // would have to enter an output register that is held by the receiver.
    assign w_adv   = !(w_ctl[R].valid && r_out_valid && i_stall);
    assign o_stall = !w_adv;

    // Square of the coordinate difference.
    edacc_square #(
        .COORD_BITS(COORD_BITS)
    ) u_square (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_adv),
        .i_valid       (i_valid),
        .i_p_coord     (i_p_coord),
        .i_q_coord     (i_q_coord),
        .i_last_element(i_last_element),
        .o_ctl         (w_sq_ctl),
        .o_sq          (w_sq)
    );

    // Saturating sum of squares.
    edacc_accum #(
        .COORD_BITS(COORD_BITS),
        .SUM_BITS  (SUM_BITS)
    ) u_accum (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_adv),
        .i_ctl  (w_sq_ctl),
        .i_sq   (w_sq),
        .o_ctl  (w_fl_ctl),
        .o_sum  (w_fl_sum)
    );

    // Head of the root row: the radicand with an empty remainder and root.
    assign w_ctl[0]  = w_fl_ctl;
    assign w_rad[0]  = NW'(w_fl_sum);
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;

    // Row of root cells, one root bit per cell, most significant first.
    for (genvar g = 0; g < R; g++) begin : g_cell
        edacc_cell #(
            .SUM_BITS(SUM_BITS)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_adv),
            .i_ctl  (w_ctl[g]),
            .i_rad  (w_rad[g]),
            .i_rem  (w_rem[g]),
            .i_root (w_root[g]),
            .o_ctl  (w_ctl[g+1]),
            .o_rad  (w_rad[g+1]),
            .o_rem  (w_rem[g+1]),
            .o_root (w_root[g+1])
        );
    end

    // Output valid: loads from the end of the row whenever the register is free
    // or its item is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            r_out_valid <= w_ctl[R].valid;
        end
    end

    // Output payload, held while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            r_out_distance <= DIST_BITS'(w_root[R]);
            r_out_sat      <= w_ctl[R].sat;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_saturated = r_out_sat;
    assign o_distance  = r_out_distance;

endmodule
`default_nettype wire

@@ test/euclidean_distance_accumulator_tb.sv @@
// Self-checking testbench for the Euclidean distance accumulator.
`timescale 1ns / 1ps
module euclidean_distance_accumulator_tb;
    import edacc_pkg::*;

    localparam int COORD_W = COORD_BITS_DEF;
    localparam int SUM_W = SUM_BITS_DEF;
    localparam logic [63:0] SUM_ALL_ONES = (64'd1 << SUM_W) - 64'd1;
    // Settle wait at the end of the run: the root width plus a margin.
    localparam int SETTLE_CYCLES = (SUM_W + 1) / 2 + 10;
    localparam int IDLE_PERCENT = 22;
    localparam int TARGET_PAIRS = 850;
    localparam int QUIET_TX_FROM = 30;
    localparam int QUIET_TX_TO = 330;
    localparam int QUIET_RX_FROM = 40;
    localparam int QUIET_RX_TO = 80;
    localparam int LONG_HOLD_AT = 25;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};

    // One coordinate pair waiting to be sent; hold_for_drain makes the sender
    // wait until every outstanding distance has been delivered.
    typedef struct {
        logic signed [COORD_W-1:0] p;
        logic signed [COORD_W-1:0] q;
        logic                      last;
        bit                        hold_for_drain;
    } t_coord_pair;

    typedef struct packed {
        logic [DIST_BITS-1:0] distance;
        logic                 saturated;
    } t_distance_result;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic signed [COORD_W-1:0] i_p_coord = '0;
    logic signed [COORD_W-1:0] i_q_coord = '0;
    logic                      i_last_element = 1'b0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic [DIST_BITS-1:0]      o_distance;
    logic                      o_saturated;

    t_coord_pair      coords_to_send[$];
    t_distance_result distances_due[$];
    t_coord_pair      next_pair;
    t_distance_result oldest_due;
    logic [63:0]      running_sum = '0;
    bit               sum_saturated = 1'b0;
    int               total_pairs = 0;
    int               pairs_accepted = 0;
    int               distances_seen = 0;
    int               mismatch_count = 0;
    int               long_hold_left = 0;
    bit               long_hold_done = 1'b0;
    int               quiet_cycles = 0;
    bit               sender_idle;

    euclidean_distance_accumulator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_p_coord      (i_p_coord),
        .i_q_coord      (i_q_coord),
        .i_last_element (i_last_element),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_distance     (o_distance),
        .o_saturated    (o_saturated)
    );

    // 20 ns clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Floor square root, built one root bit at a time from the top.
    function automatic logic [63:0] floor_root(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= n) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // Adds the square of one accepted pair to the running sum and, on the
    // last item of a vector, records the distance that must come out.
    task automatic absorb_pair(input logic signed [COORD_W-1:0] p,
                               input logic signed [COORD_W-1:0] q, input logic last);
        longint           diff;
        logic [63:0]      mag;
        logic [63:0]      sq;
        logic [63:0]      root;
        t_distance_result due;
        diff = longint'(q) - longint'(p);
        mag = (diff < 0) ? 64'(-diff) : 64'(diff);
        sq = mag * mag;
        if (sq > SUM_ALL_ONES || running_sum > SUM_ALL_ONES - sq) begin
            running_sum = SUM_ALL_ONES;
            sum_saturated = 1'b1;
        end else begin
            running_sum = running_sum + sq;
        end
        if (last) begin
            root = floor_root(running_sum);
            due.distance = root[DIST_BITS-1:0];
            due.saturated = sum_saturated;
            distances_due.push_back(due);
            running_sum = '0;
            sum_saturated = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic add_pair(input logic signed [COORD_W-1:0] p,
                            input logic signed [COORD_W-1:0] q,
                            input logic last, input bit hold_for_drain = 1'b0);
        t_coord_pair cp;
        cp.p = p;
        cp.q = q;
        cp.last = last;
        cp.hold_for_drain = hold_for_drain;
        coords_to_send.push_back(cp);
        total_pairs++;
    endtask

    // Coordinates for random vectors: mostly uniform, some extremes, some small.
    function automatic logic signed [COORD_W-1:0] pick_coord();
        int sel;
        sel = $urandom_range(99);
        if (sel < 15) begin
            case ($urandom_range(4))
                0: return C_MIN;
                1: return C_MAX;
                2: return '0;
                3: return '1;
                default: return COORD_W'(1);
            endcase
        end else if (sel < 30) begin
            return COORD_W'($signed($urandom_range(64)) - 32);
        end
        return COORD_W'($urandom);
    endfunction

    // A pair whose difference is the largest the coordinates allow.
    task automatic add_widest_pair(input logic last);
        if ($urandom_range(1)) begin
            add_pair(C_MIN, C_MAX, last);
        end else begin
            add_pair(C_MAX, C_MIN, last);
        end
    endtask

    // Sender: offers queued items, idling at random outside the quiet stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                absorb_pair(i_p_coord, i_q_coord, i_last_element);
                pairs_accepted++;
            end
            if (!i_valid || !o_stall) begin
                sender_idle = ($urandom_range(99) < IDLE_PERCENT) &&
                              !(pairs_accepted >= QUIET_TX_FROM && pairs_accepted < QUIET_TX_TO);
                if (coords_to_send.size() != 0 && !sender_idle &&
                    !(coords_to_send[0].hold_for_drain && distances_due.size() != 0)) begin
                    next_pair = coords_to_send.pop_front();
                    i_valid <= 1'b1;
                    i_p_coord <= next_pair.p;
                    i_q_coord <= next_pair.q;
                    i_last_element <= next_pair.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each delivered distance and drives the stall, with one
    // long hold-off so that the block fills and pushes back on its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                distances_seen++;
                if (distances_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected distance %0d saturated %0b",
                                              o_distance, o_saturated));
                end else begin
                    oldest_due = distances_due.pop_front();
                    if (o_distance !== oldest_due.distance) begin
                        report_mismatch($sformatf("distance %0d, expected %0d",
                                                  o_distance, oldest_due.distance));
                    end
                    if (o_saturated !== oldest_due.saturated) begin
                        report_mismatch($sformatf("saturated %0b, expected %0b",
                                                  o_saturated, oldest_due.saturated));
                    end
                end
            end
            if (long_hold_left > 0) begin
                i_stall <= 1'b1;
                long_hold_left <= long_hold_left - 1;
            end else if (!long_hold_done && distances_seen >= LONG_HOLD_AT) begin
                i_stall <= 1'b1;
                long_hold_left <= LONG_HOLD_CYCLES;
                long_hold_done <= 1'b1;
            end else if (distances_seen >= QUIET_RX_FROM && distances_seen < QUIET_RX_TO) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < IDLE_PERCENT);
            end
        end
    end

    // Watchdog: too long without any item moving on either side ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int len;
        // Single element vectors at the extremes and around zero.
        add_pair(C_MIN, C_MAX, 1'b1);
        add_pair(C_MAX, C_MIN, 1'b1);
        add_pair('0, '0, 1'b1);
        add_pair(COORD_W'(5), COORD_W'(-7), 1'b1);
        add_pair(COORD_W'(100), COORD_W'(-100), 1'b1);
        // Short vectors: an exact root, equal points and a truncated root.
        add_pair('0, COORD_W'(3), 1'b0);
        add_pair('0, COORD_W'(4), 1'b1);
        add_pair(C_MIN, C_MIN, 1'b0);
        add_pair(C_MAX, C_MAX, 1'b1);
        add_pair('0, C_MIN, 1'b0);
        add_pair(C_MAX, '0, 1'b1);
        add_pair(COORD_W'(1), '0, 1'b0);
        add_pair('0, COORD_W'(1), 1'b0);
        add_pair('0, '0, 1'b0);
        add_pair(COORD_W'(2), COORD_W'(3), 1'b1);
        add_pair('1, C_MAX, 1'b0, 1'b1);
        add_pair(C_MIN, '1, 1'b1);

        // A vector whose sum ends just below the all-ones value: largest distance.
        repeat (256) add_widest_pair(1'b0);
        add_pair('0, COORD_W'(5792), 1'b1, 1'b1);
        // A vector that saturates and keeps adding afterwards.
        repeat (256) add_widest_pair(1'b0);
        add_pair('0, COORD_W'(-5793), 1'b0);
        repeat (3) add_pair(pick_coord(), pick_coord(), 1'b0);
        add_pair(pick_coord(), pick_coord(), 1'b1);

        // Short random vectors, a few of them longer.
        while (total_pairs < TARGET_PAIRS) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(20, 7) : $urandom_range(6, 1);
            for (int k = 0; k < len; k++) begin
                add_pair(pick_coord(), pick_coord(), k == len - 1);
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pairs_accepted != total_pairs || distances_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
